// File: design/chm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// chm_pkg
// Shared types and codes of the chained hash map engine: request commands,
// sequencer states and the layout of one stored slot.
// ----------------------------------------------------------------------------
package chm_pkg;

   localparam int unsigned KEY_W   = 32;
   localparam int unsigned VALUE_W = 32;
   localparam int unsigned COUNT_W = 13;

   // request commands
   typedef enum logic [1:0] {
      CMD_FIND  = 2'd0,
      CMD_GET   = 2'd1,
      CMD_SET   = 2'd2,
      CMD_ERASE = 2'd3
   } cmd_type;

   // sequencer states, one-hot
   typedef enum logic [4:0] {
      ST_CLEAR = 5'b00001,
      ST_IDLE  = 5'b00010,
      ST_HASH  = 5'b00100,
      ST_SCAN  = 5'b01000,
      ST_WRITE = 5'b10000
   } state_type;

   // one way of a bucket as held in the slot memory
   typedef struct packed {
      logic               valid;
      logic [KEY_W-1:0]   key;
      logic [VALUE_W-1:0] value;
   } slot_type;

endpackage
`default_nettype wire

// File: design/chm_bucket_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// chm_bucket_div
// Reduces a 32-bit key to its bucket index (key modulo NUM_BUCKETS). A power
// of two bucket count is a registered mask of the low key bits. Any other count
// uses a reciprocal multiply for a quotient estimate that is at most one low,
// multiplies that estimate back on the low bits and applies one
// compare-subtract, with the key, quotient, product and bucket each registered.
// ----------------------------------------------------------------------------
module chm_bucket_div #(
   parameter int unsigned NUM_BUCKETS = 1024,
   parameter int unsigned BKT_W       = 10
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [chm_pkg::KEY_W-1:0]  key,
   output logic                            done,
   output logic [BKT_W-1:0]                bucket
);

   localparam bit IS_POW2 = ((NUM_BUCKETS & (NUM_BUCKETS - 1)) == 0);

   generate
      if (IS_POW2) begin : g_mask
         logic             done_ff;
         logic [BKT_W-1:0] bucket_ff;

         // low key bits select the bucket
         always_ff @(posedge clock) begin
            if (reset) begin
               done_ff <= 1'b0;
            end else begin
               done_ff <= start;
            end
            if (start) begin
               bucket_ff <= key[BKT_W-1:0];
            end
         end

         assign done   = done_ff;
         assign bucket = bucket_ff;
      end else begin : g_div
         localparam int unsigned KW  = chm_pkg::KEY_W;
         // remainder before correction is below twice the bucket count
         localparam int unsigned R_W = BKT_W + 1;
         localparam longint unsigned RECIP_L = (64'd1 << KW) / 64'(NUM_BUCKETS);
         localparam logic [KW-1:0]  RECIP   = RECIP_L[KW-1:0];
         localparam logic [R_W-1:0] DIVISOR = R_W'(NUM_BUCKETS);

         logic [2:0]       stage_ff;
         logic             done_ff;
         logic [KW-1:0]    key_ff;
         logic [KW-1:0]    quot_ff;
         logic [R_W-1:0]   qn_ff;
         logic [BKT_W-1:0] bucket_ff;
         logic [2*KW-1:0]  prod;
         logic [2*R_W-1:0] qn_full;
         logic [R_W-1:0]   rem_raw;
         logic [R_W-1:0]   rem_fix;

         // quotient estimate, its product on the low bits, one correction
         always_comb begin
            prod    = {{KW{1'b0}}, key_ff} * {{KW{1'b0}}, RECIP};
            qn_full = {{R_W{1'b0}}, quot_ff[R_W-1:0]} * {{R_W{1'b0}}, DIVISOR};
            rem_raw = key_ff[R_W-1:0] - qn_ff;
            rem_fix = (rem_raw >= DIVISOR) ? (rem_raw - DIVISOR) : rem_raw;
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               stage_ff <= '0;
               done_ff  <= 1'b0;
            end else begin
               stage_ff <= {stage_ff[1:0], start};
               done_ff  <= stage_ff[2];
            end
            if (start) begin
               key_ff <= key;
            end
            if (stage_ff[0]) begin
               quot_ff <= prod[2*KW-1:KW];
            end
            if (stage_ff[1]) begin
               qn_ff <= qn_full[R_W-1:0];
            end
            if (stage_ff[2]) begin
               bucket_ff <= rem_fix[BKT_W-1:0];
            end
         end

         assign done   = done_ff;
         assign bucket = bucket_ff;
      end
   endgenerate

endmodule
`default_nettype wire

// File: design/chm_slot_mem.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// chm_slot_mem
// Slot storage: one write port and one registered read port.
// ----------------------------------------------------------------------------
module chm_slot_mem #(
   parameter int unsigned DEPTH  = 4096,
   parameter int unsigned ADDR_W = 12
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire chm_pkg::slot_type wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output chm_pkg::slot_type      rd_data
);

   chm_pkg::slot_type mem [DEPTH];
   chm_pkg::slot_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// File: design/chained_hash_map_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// chained_hash_map_engine
// Key-value table with bounded chaining: find, get, set and erase requests.
// ----------------------------------------------------------------------------
// One transaction at a time. A request first passes the bucket hash
// (a mask for a power-of-two NUM_BUCKETS; otherwise a reciprocal
// multiply, a back multiply and one corrective subtract), then streams the
// bucket's ways through the single read port of the slot memory with one
// shared key compare, then goes through the write-back that gives the
// response. The sequencer is idle again the cycle after the write-back,
// and only then can the next request be taken. The response sits in an
// output register, so a new request is taken while it waits; a response
// held by rsp_stall holds the next write-back. After reset the slot memory
// is swept invalid, one slot a cycle, through all NUM_BUCKETS*BUCKET_WAYS
// slots (4096 by default), and req_stall stays high until that ends.
// ----------------------------------------------------------------------------
module chained_hash_map_engine #(
   parameter int unsigned NUM_BUCKETS = 1024,
   parameter int unsigned BUCKET_WAYS = 4
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // request channel
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic [1:0]                         req_cmd,
   input  wire logic signed [chm_pkg::KEY_W-1:0]   req_key,
   input  wire logic signed [chm_pkg::VALUE_W-1:0] req_new_value,
   // response channel
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic                                    rsp_hit,
   output logic signed [chm_pkg::VALUE_W-1:0]      rsp_read_value,
   output logic                                    rsp_removed,
   output logic                                    rsp_overflow,
   output logic [chm_pkg::COUNT_W-1:0]             rsp_entry_count
);

   localparam int unsigned SLOTS   = NUM_BUCKETS * BUCKET_WAYS;
   localparam int unsigned SLOT_W  = $clog2(SLOTS);
   localparam int unsigned BKT_W   = $clog2(NUM_BUCKETS);
   localparam int unsigned WAY_W   = (BUCKET_WAYS > 1) ? $clog2(BUCKET_WAYS) : 1;
   localparam int unsigned ISSUE_W = $clog2(BUCKET_WAYS + 1);
   localparam int unsigned CNT_W   = $clog2(SLOTS + 1);
   localparam int unsigned CW      = chm_pkg::COUNT_W;

   localparam logic [SLOT_W-1:0]  WAYS_S    = SLOT_W'(BUCKET_WAYS);
   localparam logic [SLOT_W-1:0]  LAST_SLOT = SLOT_W'(SLOTS - 1);
   localparam logic [ISSUE_W-1:0] WAYS_I    = ISSUE_W'(BUCKET_WAYS);
   localparam logic [CNT_W-1:0]   SLOTS_C   = CNT_W'(SLOTS);

   // sequencer and request state
   chm_pkg::state_type            state_ff, state_in;
   chm_pkg::cmd_type              cmd_ff;
   logic [chm_pkg::KEY_W-1:0]     key_ff;
   logic [chm_pkg::VALUE_W-1:0]   nv_ff;
   logic [BKT_W-1:0]              bucket_ff;
   logic [SLOT_W-1:0]             clr_ff;
   logic [ISSUE_W-1:0]            issue_ff;
   logic                          pend_ff;
   logic [WAY_W-1:0]              rd_way_ff;
   logic                          match_ff;
   logic [WAY_W-1:0]              match_way_ff;
   logic [chm_pkg::VALUE_W-1:0]   match_val_ff;
   logic                          free_ff;
   logic [WAY_W-1:0]              free_way_ff;
   logic [CNT_W-1:0]              cnt_ff, cnt_in;

   // response register
   logic                          rsp_valid_ff;
   logic                          rsp_hit_ff;
   logic [chm_pkg::VALUE_W-1:0]   rsp_rv_ff;
   logic                          rsp_removed_ff;
   logic                          rsp_ovf_ff;
   logic [CW-1:0]                 rsp_cnt_ff;

   logic                          req_accept;
   logic                          hash_done;
   logic [BKT_W-1:0]              hash_bucket;
   logic [SLOT_W-1:0]             base_addr;
   logic                          rd_en;
   logic [SLOT_W-1:0]             rd_addr;
   chm_pkg::slot_type             rd_data;
   logic                          wr_en;
   logic [SLOT_W-1:0]             wr_addr;
   chm_pkg::slot_type             wr_data;
   logic                          key_eq;
   logic                          write_go;
   logic                          res_removed;
   logic                          res_ovf;
   logic [chm_pkg::VALUE_W-1:0]   res_rv;
   logic [CNT_W+CW-1:0]           cnt_ext;

   assign req_stall  = (state_ff != chm_pkg::ST_IDLE);
   assign req_accept = req_valid && !req_stall;

   // bucket hash
   chm_bucket_div #(
      .NUM_BUCKETS (NUM_BUCKETS),
      .BKT_W       (BKT_W)
   ) u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (req_accept),
      .key    (req_key),
      .done   (hash_done),
      .bucket (hash_bucket)
   );

   // slot storage
   chm_slot_mem #(
      .DEPTH  (SLOTS),
      .ADDR_W (SLOT_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // way read addressing
   assign base_addr = SLOT_W'(bucket_ff) * WAYS_S;
   assign rd_en     = (state_ff == chm_pkg::ST_SCAN) && (issue_ff != WAYS_I);
   assign rd_addr   = base_addr + SLOT_W'(issue_ff);
   assign key_eq    = (rd_data.key == key_ff);
   assign write_go  = (state_ff == chm_pkg::ST_WRITE) && !(rsp_valid_ff && rsp_stall);

   // write-back decision and memory write mux
   always_comb begin
      wr_en       = 1'b0;
      wr_addr     = clr_ff;
      wr_data     = '{valid: 1'b0, key: key_ff, value: nv_ff};
      cnt_in      = cnt_ff;
      res_removed = 1'b0;
      res_ovf     = 1'b0;
      res_rv      = '0;
      if (state_ff == chm_pkg::ST_CLEAR) begin
         wr_en = 1'b1;
      end else if (write_go) begin
         case (cmd_ff)
            chm_pkg::CMD_GET, chm_pkg::CMD_SET: begin
               if (match_ff) begin
                  wr_addr = base_addr + SLOT_W'(match_way_ff);
                  wr_data = '{valid: 1'b1, key: key_ff, value: nv_ff};
                  wr_en   = (cmd_ff == chm_pkg::CMD_SET);
                  res_rv  = (cmd_ff == chm_pkg::CMD_GET) ? match_val_ff : '0;
               end else if (free_ff) begin
                  wr_addr = base_addr + SLOT_W'(free_way_ff);
                  wr_data = '{valid: 1'b1, key: key_ff,
                              value: (cmd_ff == chm_pkg::CMD_SET) ? nv_ff : '0};
                  wr_en   = 1'b1;
                  cnt_in  = cnt_ff + CNT_W'(1);
               end else begin
                  res_ovf = 1'b1;
               end
            end
            chm_pkg::CMD_ERASE: begin
               if (match_ff) begin
                  wr_addr     = base_addr + SLOT_W'(match_way_ff);
                  wr_data     = '{valid: 1'b0, key: key_ff, value: match_val_ff};
                  wr_en       = 1'b1;
                  res_removed = 1'b1;
                  if (cnt_ff != '0) begin
                     cnt_in = cnt_ff - CNT_W'(1);
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   assign cnt_ext = {{CW{1'b0}}, cnt_in};

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         chm_pkg::ST_CLEAR: if (clr_ff == LAST_SLOT) state_in = chm_pkg::ST_IDLE;
         chm_pkg::ST_IDLE:  if (req_accept) state_in = chm_pkg::ST_HASH;
         chm_pkg::ST_HASH:  if (hash_done) state_in = chm_pkg::ST_SCAN;
         chm_pkg::ST_SCAN:  if (issue_ff == WAYS_I && !pend_ff) state_in = chm_pkg::ST_WRITE;
         chm_pkg::ST_WRITE: if (write_go) state_in = chm_pkg::ST_IDLE;
         default:           state_in = chm_pkg::ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= chm_pkg::ST_CLEAR;
         clr_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         issue_ff     <= '0;
         pend_ff      <= 1'b0;
         match_ff     <= 1'b0;
         free_ff      <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         if (state_ff == chm_pkg::ST_CLEAR) begin
            clr_ff <= clr_ff + SLOT_W'(1);
         end
         if (write_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (state_ff == chm_pkg::ST_HASH) begin
            issue_ff <= '0;
            pend_ff  <= 1'b0;
            match_ff <= 1'b0;
            free_ff  <= 1'b0;
         end else if (state_ff == chm_pkg::ST_SCAN) begin
            pend_ff <= rd_en;
            if (rd_en) begin
               issue_ff <= issue_ff + ISSUE_W'(1);
            end
            // compare the way read in the previous cycle
            if (pend_ff) begin
               if (rd_data.valid) begin
                  if (!match_ff && key_eq) begin
                     match_ff <= 1'b1;
                  end
               end else if (!free_ff) begin
                  free_ff <= 1'b1;
               end
            end
         end
      end
   end

   // request and scan payload
   always_ff @(posedge clock) begin
      if (req_accept) begin
         cmd_ff <= chm_pkg::cmd_type'(req_cmd);
         key_ff <= req_key;
         nv_ff  <= req_new_value;
      end
      if (state_ff == chm_pkg::ST_HASH && hash_done) begin
         bucket_ff <= hash_bucket;
      end
      if (rd_en) begin
         rd_way_ff <= WAY_W'(issue_ff);
      end
      if (state_ff == chm_pkg::ST_SCAN && pend_ff) begin
         if (rd_data.valid) begin
            if (!match_ff && key_eq) begin
               match_way_ff <= rd_way_ff;
               match_val_ff <= rd_data.value;
            end
         end else if (!free_ff) begin
            free_way_ff <= rd_way_ff;
         end
      end
      if (write_go) begin
         rsp_hit_ff     <= match_ff;
         rsp_rv_ff      <= res_rv;
         rsp_removed_ff <= res_removed;
         rsp_ovf_ff     <= res_ovf;
         rsp_cnt_ff     <= cnt_ext[CW-1:0];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_hit         = rsp_hit_ff;
   assign rsp_read_value  = rsp_rv_ff;
   assign rsp_removed     = rsp_removed_ff;
   assign rsp_overflow    = rsp_ovf_ff;
   assign rsp_entry_count = rsp_cnt_ff;

   // a finished write-back always leaves a response behind
   a_write_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      write_go |=> rsp_valid_ff)
      else $error("write-back without response");

   // entry count stays within capacity
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= SLOTS_C)
      else $error("entry count beyond capacity");

   // the count only moves in a write-back cycle
   a_count_moves_on_write: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && (cnt_ff != $past(cnt_ff)) |-> $past(write_go))
      else $error("entry count changed outside write-back");

   // no memory write while the bucket is being scanned
   a_no_write_in_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == chm_pkg::ST_SCAN) |-> !wr_en)
      else $error("slot write during scan");

endmodule
`default_nettype wire
